// ===== rtl/ced_pkg.sv =====
// Console line editor: shared types, constants and the echo sequence table.
// Used by ced_front, ced_fifo, ced_back and console_line_editor.
// No dependencies.
package ced_pkg;

  // Line store geometry
  localparam int MAX_LINE = 32;
  localparam int CNT_W    = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
  localparam int CAP_W    = 6;
  localparam int CMP_W    = CAP_W + 1;
  localparam int LEN_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;

  // Command queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  // Configuration register indexes
  localparam logic CFG_ECHO_ENABLE   = 1'b0;
  localparam logic CFG_LINE_CAPACITY = 1'b1;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_CTRL_C = 8'h03;
  localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5e;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  // Result kinds
  localparam logic [KIND_W-1:0] K_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] K_LINE   = 2'd1;
  localparam logic [KIND_W-1:0] K_END    = 2'd2;
  localparam logic [KIND_W-1:0] K_CANCEL = 2'd3;

  // Command operations handed from front to back
  typedef enum logic [1:0] {
    OP_CHAR,
    OP_BS,
    OP_ENTER,
    OP_CANCEL
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_SEQ,
    B_LINE,
    B_END
  } back_state_t;

  // One queued command
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;   // character to store / echo
    logic [CNT_W-1:0]  cnt;    // store address for a char, length for enter
    logic              uart;   // line came over the UART only
    logic              echo;   // echo the stored character
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // One generated result from the echo table
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

  // Fixed result sequences per operation and step
  function automatic res_t seq_result(op_t op, logic [1:0] step, logic [BYTE_W-1:0] data);
    res_t r;
    r.kind = K_ECHO;
    r.data = CH_NUL;
    r.last = 1'b0;
    case (op)
      OP_CHAR: begin
        r.data = data;
        r.last = 1'b1;
      end
      OP_BS: begin
        r.data = (step == 2'd1) ? CH_SPACE : CH_BS;
        r.last = (step == 2'd2);
      end
      OP_CANCEL: begin
        case (step)
          2'd0: r.data = CH_CARET;
          2'd1: r.data = CH_C;
          2'd2: r.data = CH_LF;
          default: begin
            r.kind = K_CANCEL;
            r.last = 1'b1;
          end
        endcase
      end
      OP_ENTER: r.data = CH_LF;
      default: r.data = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ced_front.sv =====
// Front end: accepts received bytes, tracks line state, queues commands.
// Depends on ced_pkg.
module ced_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ced_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      via_console,
  input  logic                      echo_enable,
  input  logic [ced_pkg::CAP_W-1:0] line_capacity,
  input  ced_pkg::q_stat_t          q_stat,
  output logic                      push,
  output ced_pkg::cmd_t             push_cmd
);
  import ced_pkg::*;

  logic             previous_was_cr;
  logic [CNT_W-1:0] char_count;
  logic             all_from_uart;

  logic             accept;
  logic             all_next;
  logic             is_enter;
  logic             is_bs;
  logic             drop_lf;
  logic             char_ok;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_plus;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign all_next = all_from_uart && !via_console;

  // Classification
  assign is_enter   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_bs      = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
  assign drop_lf    = (rx_byte == CH_LF) && previous_was_cr && (char_count == '0);
  assign cap_eff    = (CMP_W'(line_capacity) > CMP_W'(MAX_LINE)) ? CMP_W'(MAX_LINE)
                                                                 : CMP_W'(line_capacity);
  assign count_plus = CMP_W'(char_count) + CMP_W'(1);
  assign char_ok    = (rx_byte >= CH_SPACE) && (count_plus < cap_eff);

  // Command build
  always_comb begin
    push          = 1'b0;
    push_cmd.op   = OP_CHAR;
    push_cmd.data = rx_byte;
    push_cmd.cnt  = char_count;
    push_cmd.uart = all_next;
    push_cmd.echo = echo_enable;
    if (accept && !drop_lf) begin
      if (is_enter) begin
        push        = 1'b1;
        push_cmd.op = OP_ENTER;
      end else if (rx_byte == CH_CTRL_C) begin
        push        = 1'b1;
        push_cmd.op = OP_CANCEL;
      end else if (is_bs) begin
        push        = echo_enable && (char_count != '0);
        push_cmd.op = OP_BS;
      end else if (char_ok) begin
        push        = 1'b1;
      end
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_was_cr <= 1'b0;
      char_count      <= '0;
      all_from_uart   <= 1'b1;
    end else if (accept) begin
      previous_was_cr <= drop_lf ? 1'b0 : (rx_byte == CH_CR);
      all_from_uart   <= all_next;
      if (!drop_lf) begin
        if (is_enter || (rx_byte == CH_CTRL_C)) begin
          char_count    <= '0;
          all_from_uart <= 1'b1;
        end else if (is_bs) begin
          if (char_count != '0) begin
            char_count <= CNT_W'(char_count - 1'b1);
          end
        end else if (char_ok) begin
          char_count <= CNT_W'(char_count + 1'b1);
        end
      end
    end
  end

endmodule

// ===== rtl/ced_fifo.sv =====
// Short command queue between front and back ends.
// Depends on ced_pkg.
module ced_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ced_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output ced_pkg::cmd_t    head,
  output ced_pkg::q_stat_t stat
);
  import ced_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level;

  assign head       = entries[rd_ptr];
  assign stat.valid = (level != '0);
  assign stat.full  = (level == QLVL_W'(QDEPTH));

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      case ({push, pop})
        2'b10:   level <= QLVL_W'(level + 1'b1);
        2'b01:   level <= QLVL_W'(level - 1'b1);
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== rtl/ced_back.sv =====
// Back end: runs queued commands, owns the line store and the output register.
// Depends on ced_pkg.
module ced_back (
  input  logic                       clk,
  input  logic                       rst,
  input  ced_pkg::cmd_t              q_cmd,
  input  ced_pkg::q_stat_t           q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ced_pkg::KIND_W-1:0] result_kind,
  output logic [ced_pkg::BYTE_W-1:0] out_byte,
  output logic [ced_pkg::LEN_W-1:0]  line_length,
  output logic                       uart_only,
  output logic                       last
);
  import ced_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  op_t               op;
  logic [BYTE_W-1:0] data;
  logic [CNT_W-1:0]  cnt;
  logic              uart;
  logic [1:0]        step;
  logic [1:0]        step_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_next;
  logic [BYTE_W-1:0] line_store [MAX_LINE];
  logic [BYTE_W-1:0] rd_data;

  logic              slot_free;
  logic              line_done;
  res_t              seq_res;
  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic [BYTE_W-1:0] e_data;
  logic [LEN_W-1:0]  e_len;
  logic              e_uart;
  logic              e_last;

  assign slot_free = !out_valid || out_ready;
  assign seq_res   = seq_result(op, step, data);
  assign line_done = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(cnt);
  assign pop       = (state == B_IDLE) && q_stat.valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_stat.valid && !(q_cmd.op == OP_CHAR && !q_cmd.echo)) begin
          state_next = B_SEQ;
        end
      end
      B_SEQ: begin
        if (slot_free) begin
          if (seq_res.last) begin
            state_next = B_IDLE;
          end else if (op == OP_ENTER) begin
            state_next = (cnt == '0) ? B_END : B_LINE;
          end
        end
      end
      B_LINE: begin
        if (slot_free && line_done) state_next = B_END;
      end
      B_END: begin
        if (slot_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Result generation and counters
  always_comb begin
    emit      = 1'b0;
    e_kind    = K_ECHO;
    e_data    = CH_NUL;
    e_len     = '0;
    e_uart    = 1'b0;
    e_last    = 1'b0;
    step_next = step;
    idx_next  = idx;
    case (state)
      B_IDLE: begin
        if (q_stat.valid) step_next = '0;
      end
      B_SEQ: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = seq_res.kind;
          e_data    = seq_res.data;
          e_last    = seq_res.last;
          step_next = 2'(step + 1'b1);
          if (op == OP_ENTER) idx_next = '0;
        end
      end
      B_LINE: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_kind   = K_LINE;
          e_data   = rd_data;
          idx_next = CNT_W'(idx + 1'b1);
        end
      end
      B_END: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_kind = K_END;
          e_len  = LEN_W'(cnt);
          e_uart = uart;
          e_last = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      idx       <= idx_next;
      out_valid <= emit || (out_valid && !out_ready);
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (pop) begin
      op   <= q_cmd.op;
      data <= q_cmd.data;
      cnt  <= q_cmd.cnt;
      uart <= q_cmd.uart;
    end
  end

  // Line store: one write port, one registered read port ahead of the sequencer
  always_ff @(posedge clk) begin
    if (pop && (q_cmd.op == OP_CHAR)) begin
      line_store[q_cmd.cnt] <= q_cmd.data;
    end
    rd_data <= line_store[idx_next];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= e_kind;
      out_byte    <= e_data;
      line_length <= e_len;
      uart_only   <= e_uart;
      last        <= e_last;
    end
  end

endmodule

// ===== rtl/console_line_editor.sv =====
// Console line editor top level: config registers, front end, queue, back end.
// Depends on ced_pkg, ced_front, ced_fifo, ced_back.
// Path: a byte is written into the queue, captured by the back end, then leaves the output register.
// Throughput: one result per cycle from the back-end sequencer while the output is not stalled;
// a command is popped only when the sequencer is idle. Enter gives LF, the stored characters, then the line end.
// Reset: clears line state, queue and sequencer; the line store is not cleared.
module console_line_editor (
  input  logic                       clk,
  input  logic                       rst,
  // Received bytes
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
  input  logic                       s_tuser,   // [0] via_console
  // Results
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // [7:0] out_byte, [12:8] line_length,
                                                // [13] uart_only, [15:14] zero
  output logic [1:0]                 m_tuser,   // [1:0] result_kind
  output logic                       m_tlast,   // last
  // Configuration writes
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ced_pkg::CAP_W-1:0]  cfg_wdata
);
  import ced_pkg::*;

  logic             echo_enable;
  logic [CAP_W-1:0] line_capacity;
  logic             push;
  cmd_t             push_cmd;
  cmd_t             q_head;
  q_stat_t          q_stat;
  logic             pop;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  line_length;
  logic              uart_only;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable   <= 1'b0;
      line_capacity <= CAP_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ECHO_ENABLE:   echo_enable   <= cfg_wdata[0];
        CFG_LINE_CAPACITY: line_capacity <= cfg_wdata;
        default:           echo_enable   <= echo_enable;
      endcase
    end
  end

  ced_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .rx_byte       (s_tdata),
    .via_console   (s_tuser),
    .echo_enable   (echo_enable),
    .line_capacity (line_capacity),
    .q_stat        (q_stat),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  ced_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  ced_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_cmd       (q_head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result_kind (m_tuser),
    .out_byte    (out_byte),
    .line_length (line_length),
    .uart_only   (uart_only),
    .last        (m_tlast)
  );

  assign m_tdata = {2'b00, uart_only, line_length, out_byte};

  // Line end and cancel always close the run of results for a byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == K_END || m_tuser == K_CANCEL) |-> m_tlast)
    else $error("line end or cancel result without last");

  // Line bytes are always followed by the line end marker
  a_line_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == K_LINE) |-> !m_tlast)
    else $error("line byte marked last");

  // Length and uart flag only carried by the line end marker
  a_len_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != K_END) |-> (m_tdata[13:8] == 6'd0))
    else $error("length or uart flag set outside line end");

  // Queue never takes a command while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("command queue overflow");

endmodule

// ===== verif/console_line_editor_checker.sv =====
// Line editor checker: watches the byte, result and register ports and predicts each result.
// Depends on ced_pkg for result kinds, character codes, register indexes and sizes.
// Reports its mismatch count and the number of results still due to the testbench top.
module console_line_editor_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] rx_byte
  input  logic                      s_tuser,   // [0] via_console
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [15:0]               m_tdata,   // [7:0] out_byte, [12:8] line_length, [13] uart_only
  input  logic [1:0]                m_tuser,   // [1:0] result_kind
  input  logic                      m_tlast,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ced_pkg::CAP_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        outstanding,
  output int                        bytes_taken,
  output int                        results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ced_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  line_length;
    logic              uart_only;
    logic              last;
  } console_out_t;

  // Results still owed by the block, oldest first
  console_out_t console_out_q[$];
  console_out_t next_out;

  // Shadow of the editor state and its registers
  logic              echo_on;
  logic [CAP_W-1:0]  capacity;
  logic              cr_pending;
  int                char_total;
  logic [BYTE_W-1:0] line_copy [MAX_LINE];
  logic              from_uart;

  task automatic post(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                      input int len, input logic uart);
    console_out_t r;
    r.kind        = kind;
    r.out_byte    = data;
    r.line_length = LEN_W'(len);
    r.uart_only   = uart;
    r.last        = 1'b0;
    console_out_q.push_back(r);
  endtask

  // Apply one received byte to the shadow line and queue what it should produce
  task automatic edit_byte(input logic [BYTE_W-1:0] c, input logic console);
    int first;
    int cap_lim;
    first   = console_out_q.size();
    cap_lim = (int'(capacity) > MAX_LINE) ? MAX_LINE : int'(capacity);
    // console injection taints the line even when the byte itself goes nowhere
    if (console) from_uart = 1'b0;
    // second half of a CR LF pair
    if (c == CH_LF && cr_pending && char_total == 0) begin
      cr_pending = 1'b0;
      return;
    end
    cr_pending = (c == CH_CR);
    if (c == CH_CR || c == CH_LF) begin
      post(K_ECHO, CH_LF, 0, 1'b0);
      for (int i = 0; i < char_total; i++) post(K_LINE, line_copy[i], 0, 1'b0);
      post(K_END, CH_NUL, char_total, from_uart);
      char_total = 0;
      from_uart  = 1'b1;
    end else if (c == CH_CTRL_C) begin
      post(K_ECHO, CH_CARET, 0, 1'b0);
      post(K_ECHO, CH_C, 0, 1'b0);
      post(K_ECHO, CH_LF, 0, 1'b0);
      post(K_CANCEL, CH_NUL, 0, 1'b0);
      foreach (line_copy[i]) line_copy[i] = CH_NUL;
      char_total = 0;
      from_uart  = 1'b1;
    end else if (c == CH_BS || c == CH_DEL) begin
      // erase on an empty line is silent
      if (char_total > 0) begin
        char_total--;
        if (echo_on) begin
          post(K_ECHO, CH_BS, 0, 1'b0);
          post(K_ECHO, CH_SPACE, 0, 1'b0);
          post(K_ECHO, CH_BS, 0, 1'b0);
        end
      end
    end else if (c >= CH_SPACE && char_total + 1 < cap_lim && char_total < MAX_LINE) begin
      line_copy[char_total] = c;
      char_total++;
      if (echo_on) post(K_ECHO, c, 0, 1'b0);
    end
    if (console_out_q.size() > first) console_out_q[console_out_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Registers, results and new requests are all taken at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      echo_on    = 1'b0;
      capacity   = CAP_W'(32);
      cr_pending = 1'b0;
      char_total = 0;
      from_uart  = 1'b1;
      foreach (line_copy[i]) line_copy[i] = CH_NUL;
      console_out_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ECHO_ENABLE:   echo_on = cfg_wdata[0];
          CFG_LINE_CAPACITY: capacity = cfg_wdata;
          default:           echo_on = echo_on;
        endcase
      end
      // results always belong to earlier requests, so compare before predicting
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (console_out_q.size() == 0) begin
          $error("unexpected result: kind %0d, tdata %04h", m_tuser, m_tdata);
          errors++;
        end else begin
          next_out = console_out_q.pop_front();
          check_field("result_kind", int'(next_out.kind), int'(m_tuser));
          check_field("out_byte", int'(next_out.out_byte), int'(m_tdata[7:0]));
          check_field("line_length", int'(next_out.line_length), int'(m_tdata[12:8]));
          check_field("uart_only", int'(next_out.uart_only), int'(m_tdata[13]));
          check_field("last", int'(next_out.last), int'(m_tlast));
          check_field("tdata padding", 0, int'(m_tdata[15:14]));
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        edit_byte(s_tdata, s_tuser);
      end
    end
    outstanding = console_out_q.size();
  end

endmodule

// ===== verif/console_line_editor_tb.sv =====
// Line editor testbench top: clock, reset, byte and register stimulus, final verdict.
// Depends on ced_pkg, console_line_editor and console_line_editor_checker.
module console_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ced_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;    // [7:0] rx_byte
  logic              s_tuser;    // [0] via_console
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;    // [7:0] out_byte, [12:8] line_length, [13] uart_only
  logic [1:0]        m_tuser;    // [1:0] result_kind
  logic              m_tlast;
  logic              cfg_we;
  logic              cfg_index;
  logic [CAP_W-1:0]  cfg_wdata;

  int mismatches;
  int outstanding;
  int bytes_taken;
  int results_seen;

  int send_idle_pct;
  int recv_idle_pct;
  int edits_sent;
  int reg_writes;
  int target;

  // Opening lines, {via_console, rx_byte}
  logic [8:0] opening_bytes [20] = '{
    {1'b0, CH_LF},      // empty line right after reset
    {1'b1, 8'h41},      // console-injected character
    {1'b0, CH_DEL},     // erase it
    {1'b0, CH_BS},      // erase on an empty line
    {1'b0, CH_NUL},     // ignored control
    {1'b0, 8'hff},
    {1'b0, CH_SPACE},
    {1'b0, CH_CR},      // line end, tainted by the console byte
    {1'b0, CH_LF},      // dropped as half of CR LF
    {1'b0, CH_LF},      // empty line
    {1'b0, 8'h79},
    {1'b0, CH_CR},
    {1'b1, CH_LF},      // dropped, yet still taints the next line
    {1'b0, CH_CR},
    {1'b0, 8'h71},
    {1'b0, CH_CTRL_C},  // cancel with a character held
    {1'b0, 8'h61},
    {1'b0, 8'h62},
    {1'b0, 8'h63},
    {1'b0, 8'h64}
  };

  always #6 clk = ~clk;

  console_line_editor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  console_line_editor_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .errors       (mismatches),
    .outstanding  (outstanding),
    .bytes_taken  (bytes_taken),
    .results_seen (results_seen)
  );

  // Result side back-pressure
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // One byte request; returns at the falling edge after it was taken
  task automatic send_byte(input logic [7:0] c, input logic console);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tuser  = console;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (c >= CH_SPACE || c == CH_CR || c == CH_LF || c == CH_CTRL_C || c == CH_BS)
      edits_sent++;
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CAP_W'(val);
    @(negedge clk);
    cfg_we    = 1'b0;
    reg_writes++;
  endtask

  // Block is idle once every result is out and a dropped byte has had time to settle
  task automatic wait_quiet();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_idling(input int phase);
    if (phase < 3) begin
      send_idle_pct = 24;
      recv_idle_pct = 85;
    end else if (phase < 6) begin
      send_idle_pct = 85;
      recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // A typed line: mostly printable, some erasures and noise, then an ending (or none)
  task automatic type_line();
    int len;
    int r;
    logic mixed;
    logic [7:0] c;
    mixed = 1'($urandom_range(1));
    len = ($urandom_range(9) == 0) ? $urandom_range(36, 26) : $urandom_range(6, 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8) c = $urandom_range(1) ? CH_BS : CH_DEL;
      else if (r < 13) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(255, 32));
      send_byte(c, mixed & ($urandom_range(3) == 0));
    end
    r = $urandom_range(9);
    case (r)
      0, 1, 2, 3: send_byte(CH_CR, mixed & 1'($urandom_range(1)));
      4: begin
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, mixed & 1'($urandom_range(1)));
      end
      5, 6: send_byte(CH_LF, mixed & 1'($urandom_range(1)));
      7: send_byte(CH_CTRL_C, mixed & 1'($urandom_range(1)));
      8: begin
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_LF, mixed & 1'($urandom_range(1)));
      end
      default: ;  // line stays open into the next one
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ECHO_ENABLE;
    cfg_wdata = '0;
    set_idling(0);
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed lines with echo on
    write_reg(CFG_ECHO_ENABLE, 1);
    write_reg(CFG_LINE_CAPACITY, 32);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);

    // capacity lowered below a line already held
    wait_quiet();
    write_reg(CFG_LINE_CAPACITY, 3);
    send_byte(8'h65, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(CH_CR, 1'b0);

    // random lines over several register settings
    for (int phase = 0; phase < 8; phase++) begin
      wait_quiet();
      case (phase)
        0: begin write_reg(CFG_ECHO_ENABLE, 1); write_reg(CFG_LINE_CAPACITY, 32); end
        1: begin write_reg(CFG_ECHO_ENABLE, 0); write_reg(CFG_LINE_CAPACITY, 8); end
        2: begin write_reg(CFG_ECHO_ENABLE, 1); write_reg(CFG_LINE_CAPACITY, 2); end
        3: begin write_reg(CFG_ECHO_ENABLE, 1); write_reg(CFG_LINE_CAPACITY, 63); end
        4: begin write_reg(CFG_ECHO_ENABLE, 0); write_reg(CFG_LINE_CAPACITY, 1); end
        5: begin
          write_reg(CFG_ECHO_ENABLE, 1);
          write_reg(CFG_LINE_CAPACITY, $urandom_range(31, 3));
        end
        6: begin write_reg(CFG_ECHO_ENABLE, 0); write_reg(CFG_LINE_CAPACITY, 0); end
        default: begin write_reg(CFG_ECHO_ENABLE, 1); write_reg(CFG_LINE_CAPACITY, 40); end
      endcase
      set_idling(phase);
      target = edits_sent + 17;
      while (edits_sent < target) type_line();
    end

    wait_quiet();
    $display("Summary: %0d console bytes taken under %0d register writes, echo on and off,",
             bytes_taken, reg_writes);
    $display("  capacities 0 to 63, erasures, cancels and CR LF pairs; %0d results compared",
             results_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
